/* rtl/core/assert_macros.svh */
// Assertion macros for the lens projection coordinate remap RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property checked on every rising clock edge outside reset
`define LPCR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpcr assertion failed");
// Same-cycle implication
`define LPCR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcr assertion failed");
`else
`define LPCR_ASSERT(name, clk, rst_n, prop)
`define LPCR_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/lpcr_pkg.sv */
// Shared constants, types and the arc tangent table of the coordinate remap.
// No dependencies; used by every module of the block.
package lpcr_pkg;

    localparam int COORD_WIDTH       = 32;
    localparam int CORDIC_ITERATIONS = 24;
    localparam int SAT_BITS          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int Q_W               = SAT_BITS - 1;

    // datapath widths
    localparam int XY_W      = 39;   // CORDIC x/y, signed
    localparam int Z_W       = 36;   // CORDIC angle, signed Q32 radians
    localparam int VAL_W     = 64;   // magnitude / product / reduced angle
    localparam int PHI_W     = 48;   // scaled backward angle
    localparam int NUM_W     = 64;   // divider numerator
    localparam int DEN_W     = 32;   // divider denominator
    localparam int MAG_W     = 27;   // |x|, |y| after rotation
    localparam int FQ_W      = 18;   // half of the 36-bit focal operand
    localparam int PP_W      = FQ_W + MAG_W;
    localparam int MOD_STEPS = 15;   // phi < 2^48 needs 15 subtract steps

    localparam logic [PHI_W-1:0]        PI_Q32      = 48'd13493037704;
    localparam logic [PHI_W-1:0]        HALF_PI_Q32 = 48'd6746518852;
    localparam logic signed [XY_W-1:0]  ROT_START   = 39'sd67108864;
    localparam logic [31:0] SAT_MAX = 32'((64'd1 << (SAT_BITS - 1)) - 64'd1);

    typedef enum logic {
        MODE_FWD = 1'b0,
        MODE_BWD = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_GNOMONIC = 1'b0,
        KIND_STEREO   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CFG_KIND  = 2'd0,
        CFG_FOCAL = 2'd1,
        CFG_RPP   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] focal;
        logic [31:0] rpp;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        mode_t                   mode;
        logic                    neg;
        logic                    zero;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } cordic_t;

    typedef struct packed {
        logic           valid;
        logic           neg;
        logic           zf;
        logic           sat;
        logic [Q_W-1:0] q;
    } quot_t;

    // atan(2^-i) in Q32 radians
    function automatic logic signed [Z_W-1:0] atan_q32(input int i);
        logic signed [Z_W-1:0] t;
        case (i)
            0:  t = Z_W'(33'd3373259426);
            1:  t = Z_W'(33'd1991351318);
            2:  t = Z_W'(33'd1052175346);
            3:  t = Z_W'(33'd534100635);
            4:  t = Z_W'(33'd268086748);
            5:  t = Z_W'(33'd134174063);
            6:  t = Z_W'(33'd67103403);
            7:  t = Z_W'(33'd33553749);
            8:  t = Z_W'(33'd16777131);
            9:  t = Z_W'(33'd8388597);
            10: t = Z_W'(33'd4194303);
            11: t = Z_W'(33'd2097152);
            default: t = (i <= 32) ? (Z_W'(1) << (32 - i)) : '0;
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/lens_projection_coordinate_remap.sv */
// Lens projection coordinate remap: one (x, y) pair per clock cycle, gnomonic or
// stereographic, forward (rectilinear to angular) or backward. Each axis runs
// through its own pipeline: 19 stages of magnitude, angle scaling and reduction
// mod pi, 24 CORDIC stages, 3 numerator and range-check stages, 31 divider
// stages, then the output register. Throughput is one transaction per cycle; the
// whole pipeline holds while m_tready is low and a result waits. Configuration
// writes take effect in the cycle after the transaction and are only to be made
// while no pair is in flight. Depends on lpcr_pkg, lpcr_angle, lpcr_cordic,
// lpcr_divide.
`include "assert_macros.svh"

module lens_projection_coordinate_remap (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] coord_x, [63:32] coord_y
    input  logic [0:0]  s_tuser,    // [0] mode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] result_x, [63:32] result_y
    output logic [0:0]  m_tuser,    // [0] saturated
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lpcr_pkg::cfg_t     cfg_reg;
    lpcr_pkg::cordic_t  start_x, start_y, done_x, done_y;
    lpcr_pkg::quot_t    quot_x, quot_y;

    logic        en;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [0:0]  m_tuser_reg;
    logic [31:0] mag_x, mag_y, res_x, res_y;

    // whole pipeline advances when the output register is free
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind  <= lpcr_pkg::KIND_STEREO;
            cfg_reg.focal <= 32'd4096000;
            cfg_reg.rpp   <= 32'd4294967;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lpcr_pkg::CFG_KIND:  cfg_reg.kind  <= lpcr_pkg::kind_t'(cfg_data[0]);
                lpcr_pkg::CFG_FOCAL: cfg_reg.focal <= cfg_data;
                lpcr_pkg::CFG_RPP:   cfg_reg.rpp   <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-axis pipelines
    lpcr_angle u_angle_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .coord    (s_tdata[31:0]),
        .start    (start_x)
    );

    lpcr_angle u_angle_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .coord    (s_tdata[63:32]),
        .start    (start_y)
    );

    lpcr_cordic u_cordic_x (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .start (start_x),
        .done  (done_x)
    );

    lpcr_cordic u_cordic_y (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .start (start_y),
        .done  (done_y)
    );

    lpcr_divide u_divide_x (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg_reg),
        .done  (done_x),
        .quot  (quot_x)
    );

    lpcr_divide u_divide_y (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg_reg),
        .done  (done_y),
        .quot  (quot_y)
    );

    // clip, force zero, restore sign
    always_comb
    begin
        if (quot_x.zf)
        begin
            mag_x = 32'd0;
        end
        else if (quot_x.sat)
        begin
            mag_x = lpcr_pkg::SAT_MAX;
        end
        else
        begin
            mag_x = 32'(quot_x.q);
        end
        if (quot_y.zf)
        begin
            mag_y = 32'd0;
        end
        else if (quot_y.sat)
        begin
            mag_y = lpcr_pkg::SAT_MAX;
        end
        else
        begin
            mag_y = 32'(quot_y.q);
        end
        res_x = quot_x.neg ? (~mag_x + 32'd1) : mag_x;
        res_y = quot_y.neg ? (~mag_y + 32'd1) : mag_y;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= quot_x.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {res_y, res_x};
            m_tuser_reg <= quot_x.sat | quot_y.sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // both axes carry the same transaction
    `LPCR_ASSERT(a_lane_sync, clk, rst_n, quot_x.valid == quot_y.valid)
    // a forced-zero axis never reports clipping
    `LPCR_ASSERT_IMPL(a_zero_no_sat, clk, rst_n, quot_x.valid && quot_x.zf, !quot_x.sat)
    // a raised flag means some axis sits at a range limit
    `LPCR_ASSERT_IMPL(a_sat_limit, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[31:0] == lpcr_pkg::SAT_MAX || m_tdata[31:0] == (~lpcr_pkg::SAT_MAX + 32'd1) || m_tdata[63:32] == lpcr_pkg::SAT_MAX || m_tdata[63:32] == (~lpcr_pkg::SAT_MAX + 32'd1))

endmodule

/* rtl/core/lpcr_angle.sv */
// Front end of one axis: magnitude, backward angle scaling and reduction mod pi.
// Depends on lpcr_pkg; feeds lpcr_cordic with its start vector.
module lpcr_angle (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  lpcr_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    input  logic                  in_mode,
    input  logic [31:0]           coord,
    output lpcr_pkg::cordic_t     start
);

    localparam int STEPS = lpcr_pkg::MOD_STEPS;

    typedef struct packed {
        logic                          valid;
        lpcr_pkg::mode_t               mode;
        logic                          neg;
        logic                          zero;
        logic [lpcr_pkg::VAL_W-1:0]    val;
    } ang_t;

    ang_t a_reg, a_next, b_reg, b_next, c_reg, c_next;
    ang_t m_reg  [STEPS];
    ang_t m_next [STEPS];
    lpcr_pkg::cordic_t start_reg, start_next;

    logic [31:0]                  mag;
    logic [lpcr_pkg::VAL_W-1:0]   rsum;
    ang_t                         last;
    logic [lpcr_pkg::PHI_W-1:0]   r;

    // stage A: sign and magnitude
    assign mag = coord[31] ? (~coord + 32'd1) : coord;

    always_comb
    begin
        a_next.valid = in_valid;
        a_next.mode  = lpcr_pkg::mode_t'(in_mode);
        a_next.neg   = coord[31];
        a_next.zero  = (mag == 32'd0);
        a_next.val   = lpcr_pkg::VAL_W'(mag);
    end

    // stage B: backward angle a*rpp
    always_comb
    begin
        b_next = a_reg;
        if (a_reg.mode == lpcr_pkg::MODE_BWD)
        begin
            b_next.val = a_reg.val[31:0] * cfg.rpp;
        end
    end

    // stage C: round to Q32, halved for stereographic
    always_comb
    begin
        c_next = b_reg;
        if (cfg.kind == lpcr_pkg::KIND_STEREO)
        begin
            rsum = b_reg.val + (lpcr_pkg::VAL_W'(1) << 16);
        end
        else
        begin
            rsum = b_reg.val + (lpcr_pkg::VAL_W'(1) << 15);
        end
        if (b_reg.mode == lpcr_pkg::MODE_BWD)
        begin
            if (cfg.kind == lpcr_pkg::KIND_STEREO)
            begin
                c_next.val = lpcr_pkg::VAL_W'(rsum[lpcr_pkg::VAL_W-1:17]);
            end
            else
            begin
                c_next.val = lpcr_pkg::VAL_W'(rsum[lpcr_pkg::VAL_W-1:16]);
            end
        end
    end

    // reduction mod pi (backward only): one conditional subtract of pi<<(STEPS-1-k) per stage k
    for (genvar k = 0; k < STEPS; k++)
    begin : g_mod
        localparam logic [lpcr_pkg::PHI_W-1:0] SUB = lpcr_pkg::PI_Q32 << (STEPS - 1 - k);
        ang_t src;
        if (k == 0)
        begin : g_first
            assign src = c_reg;
        end
        else
        begin : g_rest
            assign src = m_reg[k-1];
        end
        always_comb
        begin
            m_next[k] = src;
            if (src.mode == lpcr_pkg::MODE_BWD && src.val[lpcr_pkg::PHI_W-1:0] >= SUB)
            begin
                m_next[k].val = src.val - lpcr_pkg::VAL_W'(SUB);
            end
        end
    end

    // stage D: start vector for vectoring or rotation
    assign last = m_reg[STEPS-1];
    assign r    = last.val[lpcr_pkg::PHI_W-1:0];

    always_comb
    begin
        start_next.valid = last.valid;
        start_next.mode  = last.mode;
        start_next.neg   = last.neg;
        start_next.zero  = last.zero;
        if (last.mode == lpcr_pkg::MODE_BWD)
        begin
            start_next.x = lpcr_pkg::ROT_START;
            start_next.y = '0;
            if (r > lpcr_pkg::HALF_PI_Q32)
            begin
                start_next.z = lpcr_pkg::Z_W'(r - lpcr_pkg::PI_Q32);
            end
            else
            begin
                start_next.z = lpcr_pkg::Z_W'(r);
            end
        end
        else
        begin
            start_next.x = lpcr_pkg::XY_W'({cfg.focal, 4'b0000});
            start_next.y = lpcr_pkg::XY_W'(last.val[31:0]);
            start_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            start_reg <= '0;
            for (int k = 0; k < STEPS; k++)
            begin
                m_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            start_reg <= start_next;
            for (int k = 0; k < STEPS; k++)
            begin
                m_reg[k] <= m_next[k];
            end
        end
    end

    assign start = start_reg;

endmodule

/* rtl/core/lpcr_cordic.sv */
// Pipelined CORDIC of one axis: vectoring for forward, rotation for backward.
// Depends on lpcr_pkg (types, atan table).
module lpcr_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  lpcr_pkg::cordic_t  start,
    output lpcr_pkg::cordic_t  done
);

    localparam int ITER = lpcr_pkg::CORDIC_ITERATIONS;

    lpcr_pkg::cordic_t st_reg  [ITER];
    lpcr_pkg::cordic_t st_next [ITER];

    // one micro-rotation per stage
    for (genvar n = 0; n < ITER; n++)
    begin : g_iter
        lpcr_pkg::cordic_t                 src;
        logic signed [lpcr_pkg::XY_W-1:0]  xv, yv, xs, ys;
        logic signed [lpcr_pkg::Z_W-1:0]   t;
        logic                              sel;

        if (n == 0)
        begin : g_first
            assign src = start;
        end
        else
        begin : g_rest
            assign src = st_reg[n-1];
        end

        assign xv  = src.x;
        assign yv  = src.y;
        assign xs  = xv >>> n;
        assign ys  = yv >>> n;
        assign t   = lpcr_pkg::atan_q32(n);
        // rotation follows the residual angle, vectoring drives y to zero
        assign sel = (src.mode == lpcr_pkg::MODE_BWD) ? ~src.z[lpcr_pkg::Z_W-1]
                                                      : src.y[lpcr_pkg::XY_W-1];

        always_comb
        begin
            st_next[n] = src;
            if (sel)
            begin
                st_next[n].x = xv - ys;
                st_next[n].y = yv + xs;
                st_next[n].z = src.z - t;
            end
            else
            begin
                st_next[n].x = xv + ys;
                st_next[n].y = yv - xs;
                st_next[n].z = src.z + t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < ITER; n++)
            begin
                st_reg[n] <= '0;
            end
        end
        else if (en)
        begin
            for (int n = 0; n < ITER; n++)
            begin
                st_reg[n] <= st_next[n];
            end
        end
    end

    assign done = st_reg[ITER-1];

endmodule

/* rtl/core/lpcr_divide.sv */
// Back end of one axis: numerator build, overflow check and restoring divider.
// Depends on lpcr_pkg; takes lpcr_cordic results, gives a quotient record.
module lpcr_divide (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  lpcr_pkg::cfg_t     cfg,
    input  lpcr_pkg::cordic_t  done,
    output lpcr_pkg::quot_t    quot
);

    localparam int QW = lpcr_pkg::Q_W;

    typedef struct packed {
        logic                         valid;
        logic                         neg;
        logic                         zf;
        logic [lpcr_pkg::PP_W-1:0]    plo;
        logic [lpcr_pkg::PP_W-1:0]    phi;
        logic [lpcr_pkg::NUM_W-1:0]   add;
        logic [lpcr_pkg::DEN_W-1:0]   den;
    } prod_t;

    typedef struct packed {
        logic                         valid;
        logic                         neg;
        logic                         zf;
        logic                         sat;
        logic [lpcr_pkg::NUM_W-1:0]   rem;
        logic [lpcr_pkg::DEN_W-1:0]   den;
        logic [QW-1:0]                q;
    } div_t;

    prod_t p_reg, p_next;
    div_t  n_reg, n_next, s_reg, s_next;
    div_t  d_reg  [QW];
    div_t  d_next [QW];

    logic [lpcr_pkg::Z_W-1:0]          zc;
    logic signed [lpcr_pkg::XY_W-1:0]  xv, yv;
    logic [lpcr_pkg::MAG_W-1:0]        my, mx;
    logic [lpcr_pkg::FQ_W-1:0]         fq_lo, fq_hi;

    assign xv    = done.x;
    assign yv    = done.y;
    assign zc    = done.z[lpcr_pkg::Z_W-1] ? '0 : done.z;
    assign my    = lpcr_pkg::MAG_W'(yv[lpcr_pkg::XY_W-1] ? -yv : yv);
    assign mx    = lpcr_pkg::MAG_W'(xv[lpcr_pkg::XY_W-1] ? -xv : xv);
    assign fq_lo = {cfg.focal[13:0], 4'b0000};
    assign fq_hi = cfg.focal[31:14];

    // stage P: partial products (backward) or scaled angle (forward)
    always_comb
    begin
        p_next.valid = done.valid;
        if (done.mode == lpcr_pkg::MODE_BWD)
        begin
            p_next.neg = done.neg ^ yv[lpcr_pkg::XY_W-1] ^ xv[lpcr_pkg::XY_W-1];
            p_next.zf  = done.zero || (my == '0) || (cfg.focal == 32'd0);
            p_next.plo = fq_lo * my;
            p_next.phi = fq_hi * my;
            p_next.add = lpcr_pkg::NUM_W'(mx >> 1);
            p_next.den = lpcr_pkg::DEN_W'(mx);
        end
        else
        begin
            p_next.neg = done.neg;
            p_next.zf  = done.zero || (zc == '0);
            p_next.plo = '0;
            p_next.phi = '0;
            if (cfg.kind == lpcr_pkg::KIND_STEREO)
            begin
                p_next.add = (lpcr_pkg::NUM_W'(zc) << 17) + lpcr_pkg::NUM_W'(cfg.rpp >> 1);
            end
            else
            begin
                p_next.add = (lpcr_pkg::NUM_W'(zc) << 16) + lpcr_pkg::NUM_W'(cfg.rpp >> 1);
            end
            p_next.den = cfg.rpp;
        end
    end

    // stage N: rounded numerator
    always_comb
    begin
        n_next.valid = p_reg.valid;
        n_next.neg   = p_reg.neg;
        n_next.zf    = p_reg.zf;
        n_next.sat   = 1'b0;
        n_next.rem   = (lpcr_pkg::NUM_W'(p_reg.phi) << lpcr_pkg::FQ_W)
                     + lpcr_pkg::NUM_W'(p_reg.plo) + p_reg.add;
        n_next.den   = p_reg.den;
        n_next.q     = '0;
    end

    // stage S: quotient too large for the output range
    always_comb
    begin
        s_next     = n_reg;
        s_next.sat = !n_reg.zf && (n_reg.rem >= (lpcr_pkg::NUM_W'(n_reg.den) << QW));
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        div_t                         src;
        logic [lpcr_pkg::NUM_W-1:0]   dsh;
        if (k == 0)
        begin : g_first
            assign src = s_reg;
        end
        else
        begin : g_rest
            assign src = d_reg[k-1];
        end
        assign dsh = lpcr_pkg::NUM_W'(src.den) << B;
        always_comb
        begin
            d_next[k] = src;
            if (src.rem >= dsh)
            begin
                d_next[k].rem  = src.rem - dsh;
                d_next[k].q[B] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
            n_reg <= '0;
            s_reg <= '0;
            for (int k = 0; k < QW; k++)
            begin
                d_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            p_reg <= p_next;
            n_reg <= n_next;
            s_reg <= s_next;
            for (int k = 0; k < QW; k++)
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    assign quot.valid = d_reg[QW-1].valid;
    assign quot.neg   = d_reg[QW-1].neg;
    assign quot.zf    = d_reg[QW-1].zf;
    assign quot.sat   = d_reg[QW-1].sat;
    assign quot.q     = d_reg[QW-1].q;

endmodule
